// File: rtl/dda_pkg.sv
// Shared types, constants and command codes of the line/triangle rasterizer.
package dda_pkg;

   localparam int CoordBits = 12;
   localparam int FracBits  = 16;
   localparam int DiffBits  = CoordBits + 1;
   localparam int NumBits   = DiffBits + FracBits;
   localparam int AccBits   = CoordBits + FracBits + 1;
   localparam int PixBits   = 14;
   localparam int SizeBits  = 13;

   localparam logic [1:0] CMD_LOAD_LINE = 2'd0;
   localparam logic [1:0] CMD_LOAD_TRI  = 2'd1;
   localparam logic [1:0] CMD_STEP      = 2'd2;

   localparam logic [0:0] REG_WIDTH  = 1'b0;
   localparam logic [0:0] REG_HEIGHT = 1'b1;

   // Commands from controller to datapath.
   typedef struct packed {
      logic load;
      logic edge_setup;
      logic div_start;
      logic advance;
      logic next_edge;
   } dda_cmd_type;

   // Status from datapath to controller.
   typedef struct packed {
      logic div_done;
      logic at_end;
      logic final_edge;
   } dda_status_type;

endpackage

// File: rtl/dda_divider.sv
// Restoring signed divider, one quotient bit per cycle, truncation toward zero.
module dda_divider import dda_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic signed [NumBits-1:0] dividend,
   input  logic signed [DiffBits-1:0] divisor,
   output logic                      done,
   output logic signed [AccBits-1:0] quotient
);
   localparam int CntBits = $clog2(NumBits + 1);

   logic [NumBits-1:0]  quo_ff, quo_in;
   logic [DiffBits-1:0] rem_ff, rem_in;
   logic [DiffBits-1:0] den_ff, den_in;
   logic                neg_ff, neg_in;
   logic [CntBits-1:0]  cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic [DiffBits:0]   trial;
   logic [NumBits-1:0]  signed_quo;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      trial   = {rem_ff[DiffBits-1:0], quo_ff[NumBits-1]} - {1'b0, den_ff};
      // Load magnitudes, then shift one bit a cycle.
      if (start) begin
         quo_in  = dividend[NumBits-1] ? NumBits'(-dividend) : NumBits'(dividend);
         den_in  = divisor[DiffBits-1] ? DiffBits'(-divisor) : DiffBits'(divisor);
         rem_in  = '0;
         neg_in  = dividend[NumBits-1] ^ divisor[DiffBits-1];
         cnt_in  = CntBits'(NumBits);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[DiffBits]) begin
            rem_in = trial[DiffBits-1:0];
            quo_in = {quo_ff[NumBits-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[DiffBits-2:0], quo_ff[NumBits-1]};
            quo_in = {quo_ff[NumBits-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntBits'(1)) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
      if (reset) busy_ff <= 1'b0;
      else       busy_ff <= busy_in;
   end

   assign done       = !busy_ff;
   assign signed_quo = neg_ff ? -quo_ff : quo_ff;
   assign quotient   = AccBits'(signed'(signed_quo));
endmodule

// File: rtl/dda_datapath.sv
// Vertex store, edge setup, DDA stepping and pixel formation.
module dda_datapath import dda_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  dda_cmd_type                 cmd,
   output dda_status_type              status,
   input  logic                        tri_load,
   input  logic signed [CoordBits-1:0] x0, y0, x1, y1, x2, y2,
   input  logic [7:0]                  red_in, green_in, blue_in,
   input  logic [SizeBits-1:0]         screen_width, screen_height,
   output logic signed [PixBits-1:0]   pixel_x, pixel_y,
   output logic [7:0]                  red_out, green_out, blue_out
);
   logic signed [CoordBits-1:0] vx_ff [3];
   logic signed [CoordBits-1:0] vy_ff [3];
   logic [23:0]                 colour_ff;
   logic [1:0]                  edge_ff, edge_in;
   logic                        tri_ff;
   logic                        major_x_ff, major_x_in;
   logic signed [CoordBits-1:0] pos_ff, pos_in, end_ff, end_in;
   logic signed [AccBits-1:0]   acc_ff, acc_in;
   logic signed [NumBits-1:0]   num_ff, num_in;
   logic signed [DiffBits-1:0]  den_ff, den_in;
   logic                        zero_ff, zero_in;
   logic signed [AccBits-1:0]   quotient;
   logic                        div_done;

   logic [1:0]                  a_idx, b_idx;
   logic signed [CoordBits-1:0] ax, ay, bx, by, i0, d0, i1, d1;
   logic signed [DiffBits-1:0]  dx, dy, adx, ady;
   logic                        mx;
   logic signed [AccBits-1:0]   acc_adj;
   logic signed [AccBits-FracBits-1:0] minor;
   logic signed [PixBits-1:0]   vx, vy;

   dda_divider u_div (
      .clock(clock), .reset(reset), .start(cmd.div_start),
      .dividend(num_ff), .divisor(den_ff), .done(div_done), .quotient(quotient)
   );

   // Select edge endpoints and order by the major axis.
   always_comb begin
      a_idx = edge_ff;
      b_idx = (edge_ff == 2'd2) ? 2'd0 : edge_ff + 2'd1;
      ax = vx_ff[a_idx]; ay = vy_ff[a_idx];
      bx = vx_ff[b_idx]; by = vy_ff[b_idx];
      dx = DiffBits'(ax) - DiffBits'(bx);
      dy = DiffBits'(ay) - DiffBits'(by);
      adx = dx[DiffBits-1] ? -dx : dx;
      ady = dy[DiffBits-1] ? -dy : dy;
      mx = adx > ady;
      if (mx) begin
         i0 = ax; d0 = ay; i1 = bx; d1 = by;
      end else begin
         i0 = ay; d0 = ax; i1 = by; d1 = bx;
      end
      if (i0 > i1) begin
         i0 = mx ? bx : by; d0 = mx ? by : bx;
         i1 = mx ? ax : ay; d1 = mx ? ay : ax;
      end
   end

   // Next state of the stepping registers.
   always_comb begin
      edge_in    = edge_ff;
      major_x_in = major_x_ff;
      pos_in     = pos_ff;
      end_in     = end_ff;
      acc_in     = acc_ff;
      num_in     = num_ff;
      den_in     = den_ff;
      zero_in    = zero_ff;
      if (cmd.load) edge_in = '0;
      else if (cmd.next_edge) edge_in = edge_ff + 2'd1;
      if (cmd.edge_setup) begin
         major_x_in = mx;
         pos_in     = i0;
         end_in     = i1;
         acc_in     = AccBits'(d0) <<< FracBits;
         num_in     = NumBits'(DiffBits'(d1) - DiffBits'(d0)) <<< FracBits;
         den_in     = DiffBits'(i1) - DiffBits'(i0);
         zero_in    = (i1 == i0);
      end else if (cmd.advance) begin
         pos_in = pos_ff + 1'b1;
         acc_in = acc_ff + (zero_ff ? '0 : quotient);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         vx_ff[0] <= x0; vy_ff[0] <= y0;
         vx_ff[1] <= x1; vy_ff[1] <= y1;
         vx_ff[2] <= x2; vy_ff[2] <= y2;
         colour_ff <= {red_in, green_in, blue_in};
         tri_ff <= tri_load;
      end
      if (reset) edge_ff <= '0;
      else       edge_ff <= edge_in;
      major_x_ff <= major_x_in;
      pos_ff  <= pos_in;
      end_ff  <= end_in;
      acc_ff  <= acc_in;
      num_ff  <= num_in;
      den_ff  <= den_in;
      zero_ff <= zero_in;
   end

   // Truncate the accumulator toward zero and map to screen space.
   always_comb begin
      acc_adj = acc_ff[AccBits-1] ? acc_ff + AccBits'((1 << FracBits) - 1) : acc_ff;
      minor   = acc_adj[AccBits-1:FracBits];
      vx = major_x_ff ? PixBits'(pos_ff) : PixBits'(minor);
      vy = major_x_ff ? PixBits'(minor) : PixBits'(pos_ff);
   end

   assign pixel_x   = PixBits'(screen_width >> 1) + vx;
   assign pixel_y   = PixBits'(screen_height >> 1) - vy;
   assign red_out   = colour_ff[23:16];
   assign green_out = colour_ff[15:8];
   assign blue_out  = colour_ff[7:0];
   assign status.div_done   = div_done;
   assign status.at_end     = pos_ff >= end_ff;
   assign status.final_edge = tri_ff ? (edge_ff == 2'd2) : 1'b1;
endmodule

// File: rtl/dda_controller.sv
// Command sequencer: loads, edge setup, slope division and pixel stepping.
module dda_controller import dda_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  logic [1:0]     req_cmd,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output logic           rsp_last,
   output logic           out_capture,
   output dda_cmd_type    cmd,
   input  dda_status_type status
);
   typedef enum logic [2:0] {
      ST_IDLE, ST_SETUP, ST_DIV_START, ST_DIV_WAIT, ST_READY
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff, busy_in;
   logic      rv_ff, rv_in;
   logic      last_ff, last_in;
   logic      accept, is_load, is_step, can_out;

   assign can_out   = !rv_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) || (state_ff == ST_READY && can_out);
   assign accept    = req_valid && req_ready;
   assign is_load   = req_cmd == CMD_LOAD_LINE || req_cmd == CMD_LOAD_TRI;
   assign is_step   = req_cmd == CMD_STEP && busy_ff && state_ff == ST_READY;

   always_comb begin
      state_in = state_ff;
      busy_in  = busy_ff;
      rv_in    = rv_ff && !rsp_ready;
      last_in  = last_ff;
      cmd      = '0;
      out_capture = 1'b0;
      case (state_ff)
         ST_SETUP: begin
            cmd.edge_setup = 1'b1;
            state_in = ST_DIV_START;
         end
         ST_DIV_START: begin
            cmd.div_start = 1'b1;
            state_in = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (status.div_done) state_in = ST_READY;
         end
         default: ;
      endcase
      if (accept && is_load) begin
         cmd.load = 1'b1;
         busy_in  = 1'b1;
         state_in = ST_SETUP;
      end else if (accept && is_step) begin
         // Emit current pixel, then advance, move to the next edge or end the shape.
         out_capture = 1'b1;
         rv_in   = 1'b1;
         last_in = 1'b0;
         if (!status.at_end) begin
            cmd.advance = 1'b1;
         end else if (status.final_edge) begin
            last_in  = 1'b1;
            busy_in  = 1'b0;
            state_in = ST_IDLE;
         end else begin
            cmd.next_edge = 1'b1;
            state_in = ST_SETUP;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         busy_ff  <= 1'b0;
         rv_ff    <= 1'b0;
         last_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= busy_in;
         rv_ff    <= rv_in;
         last_ff  <= last_in;
      end
   end

   assign rsp_valid = rv_ff;
   assign rsp_last  = last_ff;
endmodule

// File: rtl/dda_line_triangle_rasterizer.sv
// Top level of the DDA line and wireframe triangle rasterizer.
// Usage:
//   req_* carries one item per valid/ready handshake: a load (line or
//   triangle with colour) or a step. A load gives no result; it replaces
//   any shape in progress and sets up the first edge. Each step while a
//   shape is active gives one pixel item on rsp_*; steps when idle and
//   command three are dropped.
//   Edge setup runs through the setup, divider-start and divide-wait states
//   with the slope division, one quotient bit per cycle over 29 bits, for
//   each load and edge change; req_ready is low in that time. Within an edge
//   one step is taken per cycle while rsp_ready allows, so pixels stream at
//   one per cycle, rsp_valid rising in the cycle after. The output register
//   holds a pixel while rsp_ready is low; the next step waits to replace it.
//   csr_* is an APB-style port: screen width at 0, height at 4. Write only
//   while idle. Reset clears control state and sets 640 by 480.
module dda_line_triangle_rasterizer import dda_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [1:0]                  req_cmd,
   input  logic signed [CoordBits-1:0] req_x0, req_y0, req_x1, req_y1, req_x2, req_y2,
   input  logic [7:0]                  req_red_in, req_green_in, req_blue_in,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic signed [PixBits-1:0]   rsp_pixel_x, rsp_pixel_y,
   output logic [7:0]                  rsp_red_out, rsp_green_out, rsp_blue_out,
   output logic                        rsp_last_of_shape,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [2:0]                  csr_paddr,
   input  logic [31:0]                 csr_pwdata,
   output logic [31:0]                 csr_prdata,
   output logic                        csr_pready
);
   logic [SizeBits-1:0]       width_ff, height_ff;
   dda_cmd_type               cmd;
   dda_status_type            status;
   logic                      capture;
   logic signed [PixBits-1:0] px, py;
   logic [7:0]                r, g, b;
   logic signed [PixBits-1:0] px_ff, py_ff;
   logic [23:0]               col_ff;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= SizeBits'(640);
         height_ff <= SizeBits'(480);
      end else if (csr_psel && csr_penable && csr_pwrite && csr_paddr[1:0] == 2'b00) begin
         if (csr_paddr[2] == REG_WIDTH)
            width_ff <= csr_pwdata[SizeBits-1:0];
         else if (csr_paddr[2] == REG_HEIGHT)
            height_ff <= csr_pwdata[SizeBits-1:0];
      end
   end

   assign csr_pready = 1'b1;
   always_comb begin
      csr_prdata = '0;
      case (csr_paddr)
         {REG_WIDTH, 2'b00}:  csr_prdata = 32'(width_ff);
         {REG_HEIGHT, 2'b00}: csr_prdata = 32'(height_ff);
         default: csr_prdata = '0;
      endcase
   end

   dda_controller u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .req_cmd(req_cmd), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_last(rsp_last_of_shape), .out_capture(capture), .cmd(cmd), .status(status)
   );

   dda_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .status(status),
      .tri_load(req_cmd == CMD_LOAD_TRI),
      .x0(req_x0), .y0(req_y0), .x1(req_x1), .y1(req_y1), .x2(req_x2), .y2(req_y2),
      .red_in(req_red_in), .green_in(req_green_in), .blue_in(req_blue_in),
      .screen_width(width_ff), .screen_height(height_ff),
      .pixel_x(px), .pixel_y(py), .red_out(r), .green_out(g), .blue_out(b)
   );

   // Hold the emitted pixel in the output register.
   always_ff @(posedge clock) begin
      if (capture) begin
         px_ff  <= px;
         py_ff  <= py;
         col_ff <= {r, g, b};
      end
   end

   assign rsp_pixel_x   = px_ff;
   assign rsp_pixel_y   = py_ff;
   assign rsp_red_out   = col_ff[23:16];
   assign rsp_green_out = col_ff[15:8];
   assign rsp_blue_out  = col_ff[7:0];
endmodule

// File: tb/sv/dda_line_triangle_rasterizer_test.sv
// Self-checking testbench for the DDA line and wireframe triangle rasterizer.
module dda_line_triangle_rasterizer_test;
   import dda_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   // Unused command code, dropped by the block
   localparam logic [1:0] CMD_NONE = 2'd3;

   typedef struct {
      logic signed [PixBits-1:0] px;
      logic signed [PixBits-1:0] py;
      logic [7:0]                red;
      logic [7:0]                green;
      logic [7:0]                blue;
      logic                      last;
   } pixel_type;

   typedef struct {
      logic [1:0]                  cmd;
      logic signed [CoordBits-1:0] v [6];
      logic [7:0]                  red;
      logic [7:0]                  green;
      logic [7:0]                  blue;
      bit                          typed;
      int                          px;
      int                          py;
      bit                          last;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [1:0] req_cmd = CMD_STEP;
   logic signed [CoordBits-1:0] req_x0 = '0, req_y0 = '0, req_x1 = '0;
   logic signed [CoordBits-1:0] req_y1 = '0, req_x2 = '0, req_y2 = '0;
   logic [7:0] req_red_in = '0, req_green_in = '0, req_blue_in = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [PixBits-1:0] rsp_pixel_x, rsp_pixel_y;
   logic [7:0] rsp_red_out, rsp_green_out, rsp_blue_out;
   logic rsp_last_of_shape;
   logic csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [2:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   // Typed expectation riding along with the item on offer
   bit cur_typed = 1'b0;
   pixel_type cur_pixel;

   dda_line_triangle_rasterizer dut (.*);

   // Predictor state
   int     scr_w = 640, scr_h = 480;
   int     vtx [6];
   int     edge_no;
   bit     is_tri, active, x_major;
   int     major_pos, major_stop;
   longint minor_acc, slope_q;
   logic [23:0] colour;

   pixel_type pending_pixels [$];
   int     errors = 0;
   int     loads_seen = 0, steps_seen = 0, pixels_checked = 0;
   int     send_idle_pct = 0, recv_idle_pct = 0, phase = -1;
   bit     stim_done = 1'b0;

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("CHECK FAILED");
      $finish;
   end

   // Set up the current edge: pick the major axis, order endpoints, divide slope
   function automatic void setup_edge();
      int a, b, i0, d0, i1, d1, t;
      a = edge_no % 3;
      b = (a + 1) % 3;
      x_major = ((vtx[2*a] - vtx[2*b]) < 0 ? vtx[2*b] - vtx[2*a] : vtx[2*a] - vtx[2*b]) >
                ((vtx[2*a+1] - vtx[2*b+1]) < 0 ? vtx[2*b+1] - vtx[2*a+1]
                                               : vtx[2*a+1] - vtx[2*b+1]);
      if (x_major) begin
         i0 = vtx[2*a]; d0 = vtx[2*a+1]; i1 = vtx[2*b]; d1 = vtx[2*b+1];
      end else begin
         i0 = vtx[2*a+1]; d0 = vtx[2*a]; i1 = vtx[2*b+1]; d1 = vtx[2*b];
      end
      if (i0 > i1) begin
         t = i0; i0 = i1; i1 = t;
         t = d0; d0 = d1; d1 = t;
      end
      major_pos = i0;
      major_stop = i1;
      minor_acc = longint'(d0) <<< FracBits;
      slope_q = (i1 == i0) ? 0 : (longint'(d1 - d0) <<< FracBits) / longint'(i1 - i0);
   endfunction

   // Advance the rasterizer by one accepted item; return 1 when a pixel comes out
   function automatic bit rasterize_item(input logic [1:0] cmd, input int v [6],
                                         input logic [23:0] rgb, output pixel_type p);
      longint minor, x, y, px, py;
      p = '{default: '0};
      if (cmd == CMD_LOAD_LINE || cmd == CMD_LOAD_TRI) begin
         vtx = v;
         colour = rgb;
         is_tri = (cmd == CMD_LOAD_TRI);
         edge_no = 0;
         active = 1'b1;
         setup_edge();
         return 1'b0;
      end
      if (cmd != CMD_STEP || !active) return 1'b0;
      minor = minor_acc / (longint'(1) <<< FracBits);
      x = x_major ? longint'(major_pos) : minor;
      y = x_major ? minor : longint'(major_pos);
      px = longint'(scr_w / 2) + x;
      py = longint'(scr_h / 2) - y;
      if (major_pos >= major_stop) begin
         if (edge_no >= (is_tri ? 2 : 0)) begin
            p.last = 1'b1;
            active = 1'b0;
         end else begin
            edge_no++;
            setup_edge();
         end
      end else begin
         major_pos++;
         minor_acc += slope_q;
      end
      p.px = px[PixBits-1:0];
      p.py = py[PixBits-1:0];
      {p.red, p.green, p.blue} = colour;
      return 1'b1;
   endfunction

   // Track accepted items on both channels
   always @(posedge clock) begin
      int v [6];
      pixel_type p, e;
      if (!reset && req_valid && req_ready) begin
         v = '{int'(req_x0), int'(req_y0), int'(req_x1), int'(req_y1),
               int'(req_x2), int'(req_y2)};
         if (req_cmd == CMD_STEP) steps_seen++;
         else if (req_cmd != CMD_NONE) loads_seen++;
         if (rasterize_item(req_cmd, v, {req_red_in, req_green_in, req_blue_in}, p))
            pending_pixels = {pending_pixels, (cur_typed ? cur_pixel : p)};
      end
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_pixels.size() == 0) begin
            $display("%0t: unexpected pixel x=%0d y=%0d", $time, rsp_pixel_x, rsp_pixel_y);
            errors++;
         end else begin
            e = pending_pixels.pop_front();
            pixels_checked++;
            if (rsp_pixel_x !== e.px || rsp_pixel_y !== e.py || rsp_red_out !== e.red ||
                rsp_green_out !== e.green || rsp_blue_out !== e.blue ||
                rsp_last_of_shape !== e.last) begin
               $display("%0t: pixel mismatch expected x=%0d y=%0d rgb=%h%h%h last=%b",
                        $time, e.px, e.py, e.red, e.green, e.blue, e.last);
               $display("%0t:                actual x=%0d y=%0d rgb=%h%h%h last=%b",
                        $time, rsp_pixel_x, rsp_pixel_y, rsp_red_out, rsp_green_out,
                        rsp_blue_out, rsp_last_of_shape);
               errors++;
            end
         end
      end
   end

   // Receiver: random stalls, plus one long hold-off when the last phase opens
   initial begin
      bit held = 1'b0;
      forever begin
         @(posedge clock);
         if (phase == 2 && !held) begin
            held = 1'b1;
            for (int i = 0; i < 300; i++) begin
               rsp_ready <= 1'b0;
               @(posedge clock);
            end
         end
         rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // Offer one item and hold it until accepted
   task automatic send_item(input stim_row_type r);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= r.cmd;
      {req_x0, req_y0, req_x1, req_y1, req_x2, req_y2} <=
         {r.v[0], r.v[1], r.v[2], r.v[3], r.v[4], r.v[5]};
      {req_red_in, req_green_in, req_blue_in} <= {r.red, r.green, r.blue};
      cur_typed <= r.typed;
      cur_pixel <= '{r.px[PixBits-1:0], r.py[PixBits-1:0], r.red, r.green, r.blue, r.last};
      do @(posedge clock); while (!req_ready);
   endtask

   // Write one register over the APB port while the block is idle
   task automatic write_reg(input logic [0:0] idx, input int value);
      while (pending_pixels.size() != 0) @(posedge clock);
      req_valid <= 1'b0;
      repeat (40) @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (idx == REG_WIDTH) scr_w = value;
      else scr_h = value;
   endtask

   function automatic stim_row_type mk(input logic [1:0] cmd,
                                       input int x0, y0, x1, y1, x2, y2,
                                       input int r, g, b, input bit typed = 0,
                                       input int px = 0, py = 0, input bit last = 0);
      stim_row_type s;
      s.cmd = cmd;
      s.v = '{CoordBits'(x0), CoordBits'(y0), CoordBits'(x1), CoordBits'(y1),
              CoordBits'(x2), CoordBits'(y2)};
      s.red = 8'(r); s.green = 8'(g); s.blue = 8'(b);
      s.typed = typed; s.px = px; s.py = py; s.last = last;
      return s;
   endfunction

   function automatic int pixel_count(input stim_row_type s);
      int n, a, b, dx, dy;
      n = 0;
      for (int e = 0; e < (s.cmd == CMD_LOAD_TRI ? 3 : 1); e++) begin
         a = e; b = (e + 1) % 3;
         dx = int'(s.v[2*a]) - int'(s.v[2*b]);
         dy = int'(s.v[2*a+1]) - int'(s.v[2*b+1]);
         if (dx < 0) dx = -dx;
         if (dy < 0) dy = -dy;
         n += (dx > dy ? dx : dy) + 1;
      end
      return n;
   endfunction

   // Random shape: mostly small and fully stepped, some huge and cut short
   task automatic random_shape(ref int count);
      stim_row_type ld, st;
      int base_x, base_y, steps;
      bit wide;
      wide = ($urandom_range(0, 99) < 15);
      base_x = $urandom_range(0, 4060) - 2030;
      base_y = $urandom_range(0, 4060) - 2030;
      ld = mk($urandom_range(0, 1) ? CMD_LOAD_TRI : CMD_LOAD_LINE, 0, 0, 0, 0, 0, 0,
              $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
      for (int i = 0; i < 6; i++)
         ld.v[i] = wide ? CoordBits'($urandom())
                        : CoordBits'(((i % 2) ? base_y : base_x) + $urandom_range(0, 24) - 12);
      send_item(ld);
      count++;
      steps = pixel_count(ld) + $urandom_range(0, 2);
      if (wide || $urandom_range(0, 99) < 15) steps = $urandom_range(0, 30);
      if (steps > pixel_count(ld) + 2) steps = pixel_count(ld) + 2;
      for (int i = 0; i < steps; i++) begin
         st = mk(CMD_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0);
         if ($urandom_range(0, 99) < 5) st.cmd = CMD_NONE;
         for (int k = 0; k < 6; k++) st.v[k] = CoordBits'($urandom());
         {st.red, st.green, st.blue} = 24'($urandom());
         send_item(st);
         count++;
      end
   endtask

   // Main sequence: reset, directed table, then randomized phases
   initial begin
      stim_row_type rows [$];
      int count;
      int widths [3] = '{1, 4096, 4095};
      int heights [3] = '{4096, 1, 3};
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      rows = {rows, mk(CMD_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0)};
      rows = {rows, mk(CMD_NONE, 5, 5, 5, 5, 5, 5, 1, 2, 3)};
      rows = {rows, mk(CMD_LOAD_LINE, 0, 0, 0, 0, 0, 0, 255, 0, 128)};
      rows = {rows, mk(CMD_STEP, 0, 0, 0, 0, 0, 0, 255, 0, 128, 1, 320, 240, 1)};
      rows = {rows, mk(CMD_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0)};
      rows = {rows, mk(CMD_LOAD_LINE, -2048, -2048, 2047, 2047, -2048, 2047, 0, 255, 0)};
      rows = {rows, mk(CMD_STEP, 0, 0, 0, 0, 0, 0, 0, 255, 0, 1, -1728, 2288, 0)};
      rows = {rows, mk(CMD_LOAD_LINE, 2047, 0, -2048, 5, 2047, -2048, 255, 255, 255)};
      rows = {rows, mk(CMD_STEP, 0, 0, 0, 0, 0, 0, 255, 255, 255, 1, -1728, 235, 0)};
      rows = {rows, mk(CMD_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0)};
      rows = {rows, mk(CMD_LOAD_LINE, 0, 0, 3, -2, 0, 0, 17, 34, 51)};
      repeat (4) rows = {rows, mk(CMD_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0)};
      rows = {rows, mk(CMD_LOAD_TRI, 0, 0, 2, 1, 0, 2, 200, 100, 50)};
      repeat (9) rows = {rows, mk(CMD_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0)};
      foreach (rows[i]) send_item(rows[i]);
      req_valid <= 1'b0;
      cur_typed <= 1'b0;

      // Three phases: sender-light/receiver-heavy, swapped, then no idling
      for (int ph = 0; ph < 3; ph++) begin
         write_reg(REG_WIDTH, widths[ph]);
         write_reg(REG_HEIGHT, heights[ph]);
         send_idle_pct = (ph == 0) ? 19 : (ph == 1) ? 64 : 0;
         recv_idle_pct = (ph == 0) ? 64 : (ph == 1) ? 19 : 0;
         phase = ph;
         count = 0;
         while (count < 420) random_shape(count);
         req_valid <= 1'b0;
      end
      write_reg(REG_WIDTH, 640);
      write_reg(REG_HEIGHT, 480);
      repeat (4) random_shape(count);
      req_valid <= 1'b0;

      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      $display("Ran %0d loads and %0d steps over four screen sizes, checked %0d pixels.",
               loads_seen, steps_seen, pixels_checked);
      if (errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
